[rtl/mtc_pkg.sv]
// Package for the multi-timer compare peripheral: payload types, command
// struct, register offsets. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mtc_pkg;

    localparam int LOCAL_TIMERS = 4;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_IDLE  = 2'd3
    } t_func;

    // Global register offsets
    localparam logic [12:0] A_CNT_L  = 13'h100;
    localparam logic [12:0] A_CNT_H  = 13'h104;
    localparam logic [12:0] A_CWF    = 13'h110;
    localparam logic [12:0] A_CMP_L  = 13'h200;
    localparam logic [12:0] A_CMP_H  = 13'h204;
    localparam logic [12:0] A_INCR   = 13'h208;
    localparam logic [12:0] A_GCTRL  = 13'h240;
    localparam logic [12:0] A_GSTAT  = 13'h244;
    localparam logic [12:0] A_GIEN   = 13'h248;
    localparam logic [12:0] A_GWF    = 13'h24C;
    localparam logic [12:0] LOCAL_BASE = 13'h300;

    // Local register offsets
    localparam logic [7:0] L_TICK  = 8'h00;
    localparam logic [7:0] L_TREM  = 8'h04;
    localparam logic [7:0] L_PER   = 8'h08;
    localparam logic [7:0] L_PREM  = 8'h0C;
    localparam logic [7:0] L_CTRL  = 8'h20;
    localparam logic [7:0] L_STAT  = 8'h30;
    localparam logic [7:0] L_IEN   = 8'h34;
    localparam logic [7:0] L_WF    = 8'h40;

    typedef struct packed {
        logic [1:0]  func;
        logic [12:0] address;
        logic [31:0] write_data;
    } t_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic        global_irq;
        logic [15:0] local_irq;
    } t_out;

    // Command from controller to datapath
    typedef struct packed {
        logic do_read;
        logic do_write;
        logic do_tick;
    } t_cmd;

endpackage
`default_nettype wire

[rtl/mtc_ctrl.sv]
// Controller for the multi-timer compare peripheral: handshake state
// machine that tracks a one-entry output register. Depends on mtc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mtc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire mtc_pkg::t_in  i_req,
    output mtc_pkg::t_cmd      o_cmd,
    output logic               o_load,
    output logic               o_valid,
    input  wire logic          i_ready
);
    import mtc_pkg::*;

    typedef enum logic [1:0] {
        S_EMPTY = 2'b01,
        S_FULL  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   w_acc;

    // Accept when output slot is empty or being drained this cycle
    assign o_ready = (r_state == S_EMPTY) || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign o_load  = w_acc;
    assign o_valid = (r_state == S_FULL);

    always_comb begin
        o_cmd.do_read  = w_acc && (i_req.func == FUNC_READ);
        o_cmd.do_write = w_acc && (i_req.func == FUNC_WRITE);
        o_cmd.do_tick  = w_acc && (i_req.func == FUNC_TICK);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_EMPTY: if (w_acc) n_state = S_FULL;
            S_FULL:  if (i_ready && !w_acc) n_state = S_EMPTY;
            default: n_state = S_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_EMPTY;
        else          r_state <= n_state;
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_valid) else $error("accepted request gave no result");
    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd)) else $error("more than one command");
`endif

endmodule
`default_nettype wire

[rtl/mtc_dp.sv]
// Datapath for the multi-timer compare peripheral: register file, global
// counter and comparator, local timers, result register. Depends on mtc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mtc_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mtc_pkg::t_in  i_req,
    input  wire mtc_pkg::t_cmd i_cmd,
    input  wire logic          i_load,
    output mtc_pkg::t_out      o_res
);
    import mtc_pkg::*;

    localparam int NT = LOCAL_TIMERS;

    logic [63:0] r_cnt, n_cnt;
    logic [63:0] r_cmp, n_cmp;
    logic [31:0] r_incr, n_incr;
    logic [8:0]  r_gctrl, n_gctrl;
    logic [3:0]  r_gstat, n_gstat;
    logic        r_gien, n_gien;
    logic [16:0] r_gwf, n_gwf;
    logic [1:0]  r_cwf, n_cwf;
    logic [31:0] r_trel [NT], n_trel [NT];
    logic [30:0] r_prel [NT], n_prel [NT];
    logic [31:0] r_trem [NT], n_trem [NT];
    logic [30:0] r_prem [NT], n_prem [NT];
    logic [2:0]  r_lctrl [NT], n_lctrl [NT];
    logic [5:0]  r_lflg [NT], n_lflg [NT];
    t_out        r_res, n_res;

    logic [12:0] w_loff;
    logic [4:0]  w_lidx;
    logic        w_lhit;
    logic [7:0]  w_off;
    logic [31:0] w_d;
    logic [31:0] w_rd;
    logic [15:0] w_lirq;

    // Local address decode
    assign w_loff = i_req.address - LOCAL_BASE;
    assign w_lidx = w_loff[12:8];
    assign w_lhit = (i_req.address >= LOCAL_BASE) && (w_lidx < 5'(NT));
    assign w_off  = i_req.address[7:0];
    assign w_d    = i_req.write_data;

    // Read mux
    always_comb begin
        w_rd = '0;
        if (w_lhit) begin
            for (int i = 0; i < NT; i++) begin
                if (w_lidx == 5'(i)) begin
                    case (w_off)
                        L_TICK: w_rd = r_trel[i];
                        L_TREM: w_rd = r_trem[i];
                        L_PER:  w_rd = {1'b0, r_prel[i]};
                        L_PREM: w_rd = {1'b0, r_prem[i]};
                        L_CTRL: w_rd = {29'd0, r_lctrl[i]};
                        L_STAT: w_rd = {31'd0, r_lflg[i][4]};
                        L_IEN:  w_rd = {31'd0, r_lflg[i][5]};
                        L_WF:   w_rd = {28'd0, r_lflg[i][3], 1'b0, r_lflg[i][1:0]};
                        default: w_rd = '0;
                    endcase
                end
            end
        end else begin
            case (i_req.address)
                A_CNT_L: w_rd = r_cnt[31:0];
                A_CNT_H: w_rd = r_cnt[63:32];
                A_CWF:   w_rd = {30'd0, r_cwf};
                A_CMP_L: w_rd = r_cmp[31:0];
                A_CMP_H: w_rd = r_cmp[63:32];
                A_INCR:  w_rd = r_incr;
                A_GCTRL: w_rd = {23'd0, r_gctrl};
                A_GSTAT: w_rd = {28'd0, r_gstat};
                A_GIEN:  w_rd = {31'd0, r_gien};
                A_GWF:   w_rd = {15'd0, r_gwf};
                default: w_rd = '0;
            endcase
        end
    end

    // Next state: writes and ticks
    always_comb begin
        logic [63:0] c1;
        logic        ev;
        logic [30:0] pd;
        ev = 1'b0;
        pd = '0;
        n_cnt = r_cnt; n_cmp = r_cmp; n_incr = r_incr; n_gctrl = r_gctrl;
        n_gstat = r_gstat; n_gien = r_gien; n_gwf = r_gwf; n_cwf = r_cwf;
        for (int i = 0; i < NT; i++) begin
            n_trel[i] = r_trel[i]; n_prel[i] = r_prel[i];
            n_trem[i] = r_trem[i]; n_prem[i] = r_prem[i];
            n_lctrl[i] = r_lctrl[i]; n_lflg[i] = r_lflg[i];
        end
        c1 = r_cnt + 64'd1;
        if (i_cmd.do_write) begin
            if (w_lhit) begin
                for (int i = 0; i < NT; i++) begin
                    if (w_lidx == 5'(i)) begin
                        case (w_off)
                            L_TICK: begin
                                n_trel[i] = w_d; n_trem[i] = w_d; n_lflg[i][0] = 1'b1;
                            end
                            L_PER: begin
                                n_prel[i] = w_d[30:0];
                                if (w_d[31]) n_prem[i] = w_d[30:0];
                                n_lflg[i][1] = 1'b1;
                            end
                            L_CTRL: begin
                                n_lctrl[i] = w_d[2:0]; n_lflg[i][3] = 1'b1;
                            end
                            L_STAT: if (w_d[0]) n_lflg[i][4] = 1'b0;
                            L_IEN:  n_lflg[i][5] = w_d[0];
                            L_WF: begin
                                n_lflg[i][0] = r_lflg[i][0] & ~w_d[0];
                                n_lflg[i][1] = r_lflg[i][1] & ~w_d[1];
                                n_lflg[i][3] = r_lflg[i][3] & ~w_d[3];
                            end
                            default: ;
                        endcase
                    end
                end
            end else begin
                case (i_req.address)
                    A_CNT_L: begin n_cnt[31:0] = w_d; n_cwf[0] = 1'b1; end
                    A_CNT_H: begin n_cnt[63:32] = w_d; n_cwf[1] = 1'b1; end
                    A_CWF:   n_cwf = r_cwf & ~w_d[1:0];
                    A_CMP_L: begin n_cmp[31:0] = w_d; n_gwf[0] = 1'b1; end
                    A_CMP_H: begin n_cmp[63:32] = w_d; n_gwf[1] = 1'b1; end
                    A_INCR:  begin n_incr = w_d; n_gwf[2] = 1'b1; end
                    A_GCTRL: begin n_gctrl = w_d[8:0]; n_gwf[16] = 1'b1; end
                    A_GSTAT: n_gstat = r_gstat & ~w_d[3:0];
                    A_GIEN:  n_gien = w_d[0];
                    A_GWF: begin
                        n_gwf[2:0] = r_gwf[2:0] & ~w_d[2:0];
                        n_gwf[16]  = r_gwf[16] & ~w_d[16];
                    end
                    default: ;
                endcase
            end
        end else if (i_cmd.do_tick) begin
            // Global counter and comparator
            if (r_gctrl[8]) begin
                n_cnt = c1;
                if (r_gctrl[0] && (c1 == r_cmp)) begin
                    n_gstat[0] = 1'b1;
                    if (r_gctrl[1]) n_cmp = r_cmp + {32'd0, r_incr};
                end
            end
            // Local timers, one lane each
            for (int i = 0; i < NT; i++) begin
                if (r_lctrl[i][0]) begin
                    ev = (r_trem[i] == 32'd0);
                    n_trem[i] = ev ? r_trel[i] : r_trem[i] - 32'd1;
                    if (ev && r_lctrl[i][1] && (r_prem[i] != 31'd0)) begin
                        pd = r_prem[i] - 31'd1;
                        n_prem[i] = pd;
                        if (pd == 31'd0) begin
                            n_lflg[i][4] = 1'b1;
                            if (r_lctrl[i][2]) n_prem[i] = r_prel[i];
                            else               n_lctrl[i][1] = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // Interrupt outputs from next state
    always_comb begin
        w_lirq = '0;
        for (int i = 0; i < NT; i++) w_lirq[i] = n_lflg[i][4] & n_lflg[i][5];
    end

    always_comb begin
        n_res.read_data  = i_cmd.do_read ? w_rd : 32'd0;
        n_res.global_irq = n_gstat[0] & n_gien;
        n_res.local_irq  = w_lirq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_cmp <= '0; r_incr <= '0; r_gctrl <= '0;
            r_gstat <= '0; r_gien <= 1'b0; r_gwf <= '0; r_cwf <= '0;
            for (int i = 0; i < NT; i++) begin
                r_trel[i] <= '0; r_prel[i] <= '0; r_trem[i] <= '0;
                r_prem[i] <= '0; r_lctrl[i] <= '0; r_lflg[i] <= '0;
            end
        end else begin
            r_cnt <= n_cnt; r_cmp <= n_cmp; r_incr <= n_incr; r_gctrl <= n_gctrl;
            r_gstat <= n_gstat; r_gien <= n_gien; r_gwf <= n_gwf; r_cwf <= n_cwf;
            for (int i = 0; i < NT; i++) begin
                r_trel[i] <= n_trel[i]; r_prel[i] <= n_prel[i];
                r_trem[i] <= n_trem[i]; r_prem[i] <= n_prem[i];
                r_lctrl[i] <= n_lctrl[i]; r_lflg[i] <= n_lflg[i];
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_load) r_res <= n_res;
    end

    assign o_res = r_res;

`ifndef SYNTHESIS
    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.do_write && !i_cmd.do_tick) |=> $stable(r_cnt))
        else $error("counter moved without request");
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && !i_cmd.do_read) |=> (r_res.read_data == 32'd0))
        else $error("nonzero read data on non-read");
    a_cnt_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_tick && r_gctrl[8]) |=> (r_cnt == $past(r_cnt) + 64'd1))
        else $error("counter did not advance on tick");
`endif

endmodule
`default_nettype wire

[rtl/multi_timer_compare_peripheral.sv]
// Top level of the multi-timer compare peripheral: ties the controller and
// datapath together. Depends on mtc_pkg, mtc_ctrl, mtc_dp.
//
// Usage: each request on the input channel (i_valid/o_ready, i_req) is a
// register read, a register write, one timer clock tick or a no-op. Every request
// gives exactly one result on the output channel (o_valid/i_ready, o_res):
// read data (zero for anything but a mapped read) and the global and local
// interrupt lines as they stand after the request.
// Output: the result is registered and appears in the cycle after acceptance.
// Throughput: one request per cycle while i_ready is high; the state update of a
// request is done in the cycle it is accepted, so the next request sees it at once.
// Stall: one output register holds the result; while it is full and the
// receiver holds i_ready low, o_ready is low. With i_ready high, a new
// request is taken in the same cycle the old result leaves.
// Reset: synchronous, active low; clears all counters, timers, flags and the
// output register's valid.
`timescale 1ns / 1ps
`default_nettype none
module multi_timer_compare_peripheral (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire mtc_pkg::t_in  i_req,
    output logic               o_valid,
    input  wire logic          i_ready,
    output mtc_pkg::t_out      o_res
);
    import mtc_pkg::*;

    t_cmd w_cmd;
    logic w_load;

    mtc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_cmd   (w_cmd),
        .o_load  (w_load),
        .o_valid (o_valid),
        .i_ready (i_ready)
    );

    mtc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .i_load  (w_load),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire
